>>> src/pid_controller_clamped_terms_macros.svh
// Assertion helpers shared by the PID block.
// Every check is clocked on i_clk and switched off while i_rst_n is low.
`ifndef PID_CONTROLLER_CLAMPED_TERMS_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TERMS_MACROS_SVH

// The condition holds, so the consequence holds in the same cycle.
`define PIDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The condition holds, so the consequence holds in the next cycle.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pidc_pkg.sv
package pidc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DLIM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIM = 3'd7;

    // Register reset values.
    localparam logic signed [31:0] RST_KP   = 32'sd65536;
    localparam logic signed [31:0] RST_KI   = 32'sd65536;
    localparam logic signed [31:0] RST_KD   = 32'sd0;
    localparam logic [30:0]        RST_DT   = 31'd655;
    localparam logic [30:0]        RST_PLIM = 31'd65470464;
    localparam logic [30:0]        RST_ILIM = 31'd65470464;
    localparam logic [30:0]        RST_DLIM = 31'd32768000;
    localparam logic [30:0]        RST_OLIM = 31'd65470464;

    // Serial divider geometry: 64 dividend bits, two quotient bits a cycle.
    localparam int DIV_BITS    = 64;
    localparam int DIV_RADIX   = 2;
    localparam int DIV_CYCLES  = DIV_BITS / DIV_RADIX;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    // Microcode fields.
    localparam int STEP_W = 4;

    localparam logic [1:0] COND_NONE = 2'd0;
    localparam logic [1:0] COND_IN   = 2'd1;
    localparam logic [1:0] COND_DIV  = 2'd2;
    localparam logic [1:0] COND_OUT  = 2'd3;

    localparam logic [1:0] MUL_KP_ERR   = 2'd0;
    localparam logic [1:0] MUL_KI_DT    = 2'd1;
    localparam logic [1:0] MUL_ERR_KIDT = 2'd2;
    localparam logic [1:0] MUL_KD_DIFF  = 2'd3;

    localparam logic [3:0] WR_NONE  = 4'd0;
    localparam logic [3:0] WR_ERR   = 4'd1;
    localparam logic [3:0] WR_DELTA = 4'd2;
    localparam logic [3:0] WR_P     = 4'd3;
    localparam logic [3:0] WR_KIDT  = 4'd4;
    localparam logic [3:0] WR_ACC   = 4'd5;
    localparam logic [3:0] WR_DIFF  = 4'd6;
    localparam logic [3:0] WR_D     = 4'd7;
    localparam logic [3:0] WR_DRIVE = 4'd8;

    // Program addresses.
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_DELTA    = 4'd1;
    localparam logic [STEP_W-1:0] ST_PROP     = 4'd2;
    localparam logic [STEP_W-1:0] ST_KIDT     = 4'd3;
    localparam logic [STEP_W-1:0] ST_IMUL     = 4'd4;
    localparam logic [STEP_W-1:0] ST_ACC      = 4'd5;
    localparam logic [STEP_W-1:0] ST_DIFF     = 4'd6;
    localparam logic [STEP_W-1:0] ST_DMUL     = 4'd7;
    localparam logic [STEP_W-1:0] ST_DTERM    = 4'd8;
    localparam logic [STEP_W-1:0] ST_DRIVE    = 4'd9;

    typedef struct packed {
        logic [1:0]        cond;
        logic              mul_en;
        logic [1:0]        mul_sel;
        logic [3:0]        wr_sel;
        logic              div_start;
        logic              jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic t_ctrl f_word(input logic [1:0] cond, input logic mul_en,
                                     input logic [1:0] mul_sel, input logic [3:0] wr_sel,
                                     input logic div_start, input logic jmp,
                                     input logic [STEP_W-1:0] target);
        t_ctrl w;
        w.cond      = cond;
        w.mul_en    = mul_en;
        w.mul_sel   = mul_sel;
        w.wr_sel    = wr_sel;
        w.div_start = div_start;
        w.jmp       = jmp;
        w.target    = target;
        return w;
    endfunction

    // Control store. A step whose condition is false repeats.
    function automatic t_ctrl f_ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            ST_IDLE:  w = f_word(COND_IN,   1'b0, MUL_KP_ERR,   WR_ERR,   1'b0, 1'b0, ST_IDLE);
            ST_DELTA: w = f_word(COND_NONE, 1'b1, MUL_KP_ERR,   WR_DELTA, 1'b0, 1'b0, ST_IDLE);
            ST_PROP:  w = f_word(COND_NONE, 1'b1, MUL_KI_DT,    WR_P,     1'b1, 1'b0, ST_IDLE);
            ST_KIDT:  w = f_word(COND_NONE, 1'b0, MUL_KP_ERR,   WR_KIDT,  1'b0, 1'b0, ST_IDLE);
            ST_IMUL:  w = f_word(COND_NONE, 1'b1, MUL_ERR_KIDT, WR_NONE,  1'b0, 1'b0, ST_IDLE);
            ST_ACC:   w = f_word(COND_NONE, 1'b0, MUL_KP_ERR,   WR_ACC,   1'b0, 1'b0, ST_IDLE);
            ST_DIFF:  w = f_word(COND_DIV,  1'b0, MUL_KP_ERR,   WR_DIFF,  1'b0, 1'b0, ST_IDLE);
            ST_DMUL:  w = f_word(COND_NONE, 1'b1, MUL_KD_DIFF,  WR_NONE,  1'b0, 1'b0, ST_IDLE);
            ST_DTERM: w = f_word(COND_NONE, 1'b0, MUL_KP_ERR,   WR_D,     1'b0, 1'b0, ST_IDLE);
            ST_DRIVE: w = f_word(COND_OUT,  1'b0, MUL_KP_ERR,   WR_DRIVE, 1'b0, 1'b1, ST_IDLE);
            default:  w = f_word(COND_NONE, 1'b0, MUL_KP_ERR,   WR_NONE,  1'b0, 1'b1, ST_IDLE);
        endcase
        return w;
    endfunction

    // Clamp a wide value to plus or minus a 31-bit magnitude.
    function automatic logic signed [31:0] f_clamp(input logic signed [63:0] v,
                                                   input logic [30:0] lim);
        logic signed [63:0] lim64;
        logic signed [63:0] r;
        lim64 = signed'({33'd0, lim});
        if (v > lim64) begin
            r = lim64;
        end else if (v < -lim64) begin
            r = -lim64;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

endpackage

>>> src/pidc_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
module pidc_div
    import pidc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [30:0]         i_divisor,
    output t_div_stat           o_stat,
    output logic [DIV_BITS-1:0] o_quot
);

    logic [30:0]          r_rem;
    logic [30:0]          n_rem;
    logic [DIV_BITS-1:0]  r_work;
    logic [DIV_BITS-1:0]  n_work;
    logic [30:0]          r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [31:0]          trial;

    // The work register shifts dividend bits out at the top and quotient bits in.
    always_comb begin
        n_rem  = r_rem;
        n_work = r_work;
        trial  = '0;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial  = {n_rem, n_work[DIV_BITS-1]};
            n_work = {n_work[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial     = trial - {1'b0, r_div};
                n_work[0] = 1'b1;
            end
            n_rem = trial[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_work;

endmodule

>>> src/pid_controller_clamped_terms.sv
// PID controller with clamped terms, signed Q16.16. Each accepted item (setpoint, measured)
// yields one drive value. The error is saturated, the proportional term kp*error is
// clamped to +-p_limit, the integral accumulates error*(ki*dt) within +-i_limit, the
// derivative term kd*(error change)/dt is clamped to +-d_limit, and the sum is clamped to
// +-out_limit. A zero sample_period acts as the smallest step. Products are shifted right
// by FRAC_BITS with rounding toward minus infinity; intermediates saturate to
// min(VALUE_WIDTH, 32) bits. Most of the time per item goes to the serial divider that
// forms the error change over dt at two quotient bits per cycle; several of the remaining
// steps use the shared 32x32 multiplier. A new item is taken once the previous one has
// reached its last step, so the finished drive value may wait in the output register while
// the next item is computed; a result that is held off past that point holds the last step
// and stalls the input. Configuration writes are accepted in every cycle and should be
// issued only while the block is idle.
`include "pid_controller_clamped_terms_macros.svh"

module pid_controller_clamped_terms
    import pidc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Item input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_setpoint,
    input  logic signed [31:0]   i_measured,
    // Result channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_drive,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Saturation width of the error, error change, kidt and diff values.
    localparam int SAT_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;

    function automatic logic signed [SAT_W-1:0] f_sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX;
        end else if (v < SAT_MIN) begin
            r = SAT_MIN;
        end else begin
            r = v;
        end
        return r[SAT_W-1:0];
    endfunction

    // Configuration registers.
    logic signed [31:0] r_kp, r_ki, r_kd;
    logic [30:0]        r_dt, r_plim, r_ilim, r_dlim, r_olim;

    // Sequencer.
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              fire;

    // Datapath registers. r_last_err and r_acc are the controller state.
    logic signed [SAT_W-1:0] r_err, r_last_err, r_delta, r_kidt, r_diff;
    logic signed [31:0]      r_p, r_d, r_acc;
    logic signed [63:0]      r_prod;
    logic                    r_out_valid;
    logic signed [31:0]      r_drive;

    // Datapath logic.
    logic signed [31:0]  mul_a, mul_b;
    logic [30:0]         dt_eff;
    logic signed [63:0]  shifted;
    logic signed [63:0]  delta64;
    logic [63:0]         dividend;
    logic signed [63:0]  quot_s;
    logic signed [63:0]  total;
    t_div_stat           div_stat;
    logic [DIV_BITS-1:0] div_quot;
    logic                div_start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= RST_KP;
            r_ki   <= RST_KI;
            r_kd   <= RST_KD;
            r_dt   <= RST_DT;
            r_plim <= RST_PLIM;
            r_ilim <= RST_ILIM;
            r_dlim <= RST_DLIM;
            r_olim <= RST_OLIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KP:   r_kp   <= i_cfg_data;
                CFG_KI:   r_ki   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                CFG_DT:   r_dt   <= i_cfg_data[30:0];
                CFG_PLIM: r_plim <= i_cfg_data[30:0];
                CFG_ILIM: r_ilim <= i_cfg_data[30:0];
                CFG_DLIM: r_dlim <= i_cfg_data[30:0];
                CFG_OLIM: r_olim <= i_cfg_data[30:0];
            endcase
        end
    end

    // A step runs when its wait condition is met; otherwise it repeats. The last step
    // waits until the output register is empty or is being emptied in this cycle.
    assign ctrl = f_ucode(r_step);

    always_comb begin
        unique case (ctrl.cond)
            COND_NONE: fire = 1'b1;
            COND_IN:   fire = i_valid;
            COND_DIV:  fire = div_stat.done;
            COND_OUT:  fire = !r_out_valid || !i_stall;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (fire) begin
            n_step = ctrl.jmp ? ctrl.target : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_stall = (r_step != ST_IDLE);

    // Shared multiplier; the product is registered before any use.
    assign dt_eff = (r_dt == '0) ? 31'd1 : r_dt;

    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_KP_ERR: begin
                mul_a = r_kp;
                mul_b = 32'(r_err);
            end
            MUL_KI_DT: begin
                mul_a = r_ki;
                mul_b = signed'({1'b0, dt_eff});
            end
            MUL_ERR_KIDT: begin
                mul_a = 32'(r_err);
                mul_b = 32'(r_kidt);
            end
            MUL_KD_DIFF: begin
                mul_a = r_kd;
                mul_b = 32'(r_diff);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.mul_en) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
    end

    // Arithmetic shift of a product is a floor division by 2^FRAC_BITS.
    assign shifted = r_prod >>> FRAC_BITS;

    // The divider works on the magnitude of the error change; the sign is applied after.
    assign delta64  = 64'(r_delta);
    assign dividend = (r_delta < 0) ? 64'(-delta64) << FRAC_BITS : 64'(delta64) << FRAC_BITS;
    assign quot_s   = signed'(div_quot);
    assign total    = 64'(r_p) + 64'(r_acc) + 64'(r_d);
    assign div_start = fire && ctrl.div_start;

    pidc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (dt_eff),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Controller state resets to zero; the remaining datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_acc      <= '0;
        end else if (fire) begin
            if (ctrl.wr_sel == WR_DELTA) begin
                r_last_err <= r_err;
            end
            if (ctrl.wr_sel == WR_ACC) begin
                r_acc <= f_clamp(64'(r_acc) + shifted, r_ilim);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            unique case (ctrl.wr_sel)
                WR_ERR:   r_err   <= f_sat(64'(i_setpoint) - 64'(i_measured));
                WR_DELTA: r_delta <= f_sat(64'(r_err) - 64'(r_last_err));
                WR_P:     r_p     <= f_clamp(shifted, r_plim);
                WR_KIDT:  r_kidt  <= f_sat(shifted);
                WR_DIFF:  r_diff  <= f_sat((r_delta < 0) ? -quot_s : quot_s);
                WR_D:     r_d     <= f_clamp(shifted, r_dlim);
                WR_DRIVE: r_drive <= f_clamp(total, r_olim);
                default: begin
                end
            endcase
        end
    end

    // Output register: filled by the last program step, emptied by a transfer out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (ctrl.wr_sel == WR_DRIVE)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

    `PIDC_ASSERT_NEXT(a_accept_advances, (r_step == ST_IDLE) && i_valid, r_step == ST_DELTA, "accepted item did not start the program")
    `PIDC_ASSERT_NEXT(a_div_starts, div_start, div_stat.busy && !div_stat.done, "divider did not start")
    `PIDC_ASSERT_SAME(a_div_alive, r_step == ST_DIFF, div_stat.busy || div_stat.done, "waiting on an idle divider")
    `PIDC_ASSERT_SAME(a_out_source, $rose(r_out_valid), $past(r_step) == ST_DRIVE, "result appeared outside the drive step")

endmodule

>>> sim/pid_controller_clamped_terms_checker.sv
module pid_controller_clamped_terms_checker
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [31:0]   setpoint,
    input  logic signed [31:0]   measured,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [31:0]   drive,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_BITS = 16;
    localparam longint VALUE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint VALUE_MIN = -VALUE_MAX - 1;

    typedef struct {
        int unsigned        seq;
        logic signed [31:0] drive;
    } t_drive_expect;

    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [30:0]        period;
    logic [30:0]        lim_p;
    logic [30:0]        lim_i;
    logic [30:0]        lim_d;
    logic [30:0]        lim_out;
    longint             prev_error;
    longint             integral;
    int unsigned        items_seen;
    t_drive_expect      expected_drives[$];

    function automatic longint saturate(input longint v);
        if (v > VALUE_MAX) begin
            return VALUE_MAX;
        end
        if (v < VALUE_MIN) begin
            return VALUE_MIN;
        end
        return v;
    endfunction

    function automatic longint clamp_to(input longint v, input logic [30:0] lim);
        longint m;
        m = longint'(lim);
        if (v > m) begin
            return m;
        end
        if (v < -m) begin
            return -m;
        end
        return v;
    endfunction

    task automatic restore_defaults();
        gain_p     = RST_KP;
        gain_i     = RST_KI;
        gain_d     = RST_KD;
        period     = RST_DT;
        lim_p      = RST_PLIM;
        lim_i      = RST_ILIM;
        lim_d      = RST_DLIM;
        lim_out    = RST_OLIM;
        prev_error = 0;
        integral   = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_KP:   gain_p  = data;
            CFG_KI:   gain_i  = data;
            CFG_KD:   gain_d  = data;
            CFG_DT:   period  = data[30:0];
            CFG_PLIM: lim_p   = data[30:0];
            CFG_ILIM: lim_i   = data[30:0];
            CFG_DLIM: lim_d   = data[30:0];
            CFG_OLIM: lim_out = data[30:0];
            default:  ;
        endcase
    endtask

    // One control step: advances the error history and the integral, returns the drive.
    function automatic logic signed [31:0] pid_update(input logic signed [31:0] sp,
                                                      input logic signed [31:0] ms);
        longint err;
        longint delta;
        longint dt;
        longint rate;
        longint p_term;
        longint ki_dt;
        longint d_term;
        longint total;
        dt = (period == '0) ? 64'sd1 : longint'(period);
        err   = saturate(longint'(sp) - longint'(ms));
        delta = saturate(err - prev_error);
        rate  = saturate((delta * (longint'(1) << FRAC_BITS)) / dt);
        prev_error = err;
        p_term   = clamp_to((longint'(gain_p) * err) >>> FRAC_BITS, lim_p);
        ki_dt    = saturate((longint'(gain_i) * dt) >>> FRAC_BITS);
        integral = clamp_to(integral + ((err * ki_dt) >>> FRAC_BITS), lim_i);
        d_term   = clamp_to((longint'(gain_d) * rate) >>> FRAC_BITS, lim_d);
        total    = clamp_to(p_term + integral + d_term, lim_out);
        return total[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Reset is held at the start of the run, which also clears the counters.
    always @(posedge clk) begin
        t_drive_expect want;
        if (!rst_n) begin
            restore_defaults();
            expected_drives.delete();
            fail_count = 0;
            items_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
            end
            if (out_valid && !out_stall) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch($sformatf("drive %0d transferred with nothing outstanding",
                                              drive));
                end else begin
                    want = expected_drives.pop_front();
                    if (drive !== want.drive) begin
                        report_mismatch($sformatf("item %0d: drive %0d, expected %0d",
                                                  want.seq, drive, want.drive));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                want.seq   = items_seen;
                want.drive = pid_update(setpoint, measured);
                expected_drives.push_back(want);
                items_seen++;
            end
        end
        pending = expected_drives.size();
    end

endmodule

>>> sim/pid_controller_clamped_terms_tb.sv
module pid_controller_clamped_terms_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pidc_pkg::*;

    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Cycles allowed after the last expected drive value, to catch stray transfers.
    localparam int TAIL_CYCLES  = 60;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 128;
    // Receiver hold-off long enough to fill the block and back up the sender.
    localparam int HOLD_CYCLES  = 500;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] ONES  = 32'hFFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [31:0]   i_setpoint;
    logic signed [31:0]   i_measured;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [31:0]   o_drive;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    int fail_count;
    int pending_drives;
    int cycle_count;

    // Idling controls: chance in percent that the sender skips a cycle and that the
    // receiver stalls a cycle, plus a request for one long hold-off by the receiver.
    int   idle_pct;
    int   stall_pct;
    logic hold_req;

    // Simulated plant used to build realistic control-loop trajectories.
    int target;
    int plant;

    pid_controller_clamped_terms DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive     (o_drive),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The checker sees every transfer on all three channels, predicts each drive value
    // and compares it; this module only generates traffic and reports the verdict.
    pid_controller_clamped_terms_checker drive_check (
        .clk        (i_clk),
        .rst_n      (i_rst_n),
        .in_valid   (i_valid),
        .in_stall   (o_stall),
        .setpoint   (i_setpoint),
        .measured   (i_measured),
        .out_valid  (o_valid),
        .out_stall  (i_stall),
        .drive      (o_drive),
        .cfg_valid  (i_cfg_valid),
        .cfg_ready  (o_cfg_ready),
        .cfg_index  (i_cfg_index),
        .cfg_data   (i_cfg_data),
        .fail_count (fail_count),
        .pending    (pending_drives)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** pid_controller_clamped_terms: FAILED **");
        $finish;
    end

    // Result receiver. A requested hold-off takes priority over the random stall; it is
    // counted down here, one cycle at a time, independent of the sender.
    initial begin
        int   hold_left;
        logic hold_taken;
        i_stall    = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offers one item and returns on the falling edge after its transfer. Valid is left
    // high so back-to-back items do not drop it; callers lower it when a burst ends.
    task automatic send_item(input logic [31:0] sp, input logic [31:0] ms);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every predicted drive value has transferred.
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_drives != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Registers are only rewritten once the block has delivered everything, so a
    // setting never changes underneath an item that is still being computed.
    task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [31:0] kd, input logic [31:0] dt,
                                 input logic [31:0] plim, input logic [31:0] ilim,
                                 input logic [31:0] dlim, input logic [31:0] olim);
        pause_until_drained();
        write_register(CFG_KP, kp);
        write_register(CFG_KI, ki);
        write_register(CFG_KD, kd);
        write_register(CFG_DT, dt);
        write_register(CFG_PLIM, plim);
        write_register(CFG_ILIM, ilim);
        write_register(CFG_DLIM, dlim);
        write_register(CFG_OLIM, olim);
        i_cfg_valid <= 1'b0;
    endtask

    // Gains: the signed extremes and zero now and then, mostly modest values within
    // plus or minus 4.0, sometimes any bit pattern at all.
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return Q_MIN;
            1:       return Q_MAX;
            2:       return '0;
            3:       return $urandom;
            default: return $urandom_range(0, 2 * 262144) - 262144;
        endcase
    endfunction

    // Sample period: zero (treated as the smallest step), one, the maximum, raw patterns
    // whose top bit the register drops, and mostly values from 1 up to 4 * 65536.
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return ONES;
            3:       return $urandom;
            default: return $urandom_range(1, 4 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2:       return Q_MAX;
            3:       return $urandom;
            default: return $urandom_range(0, 2000 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return ONES;
            default: return Q_ONE;
        endcase
    endfunction

    // Most items follow a first-order plant chasing a slowly stepping target, so the
    // integral and derivative paths see a believable loop. The rest are full-range
    // noise and extreme values that drive the saturation paths.
    task automatic next_random_item(output logic [31:0] sp, output logic [31:0] ms);
        int unsigned kind;
        int          noise;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            if ($urandom_range(0, 9) == 0) begin
                target = $urandom_range(0, 1 << 24) - (1 << 23);
            end
            noise = $urandom_range(0, 1 << 19) - (1 << 18);
            plant = plant + ((target - plant) >>> 3) + noise;
            sp = target;
            ms = plant;
        end else if (kind < 85) begin
            sp = $urandom;
            ms = $urandom;
        end else begin
            sp = pick_extreme();
            ms = pick_extreme();
        end
    endtask

    initial begin
        logic [31:0] sp;
        logic [31:0] ms;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_setpoint  = '0;
        i_measured  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KP;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        target      = 0;
        plant       = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the reset settings: zero error, a unit error, then
        // error swings large enough that both the error and its change saturate.
        send_item('0, '0);
        send_item(Q_ONE, '0);
        send_item(Q_MAX, Q_MIN);
        send_item(Q_MIN, Q_MAX);
        send_item(Q_MIN, Q_MIN);
        send_item(Q_MAX, ONES);
        send_item(ONES, '0);

        // Extreme gains with a zero sample period, and every limit written with its
        // top bit set so only the 31-bit magnitude survives.
        load_settings(Q_MAX, Q_MIN, Q_ONE, '0, ONES, ONES, ONES, ONES);
        send_item('0, '0);
        send_item(32'd1, '0);
        send_item(Q_MAX, Q_MIN);
        send_item(Q_MIN, Q_MAX);
        send_item(32'd100, -32'sd100);
        send_item(Q_MIN, '0);

        // Zero limits on the proportional term and the output, the smallest period.
        load_settings(Q_MIN, Q_MIN, Q_MIN, 32'd1, '0, Q_MAX, Q_ONE, '0);
        send_item(Q_ONE, '0);
        send_item(Q_MIN, Q_MAX);
        send_item(Q_MAX, '0);
        send_item('0, '0);

        // Largest period, so the derivative nearly vanishes while ki*dt saturates.
        load_settings(-32'sd65536, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 32'd655360);
        send_item(Q_ONE, '0);
        send_item(Q_MAX, Q_MIN);
        send_item(ONES, 32'd1);
        send_item(Q_MIN, Q_MAX);

        // Random part. Each phase loads a fresh setting and uses one of the idling
        // patterns; halfway through, the sender stops until every result is back.
        for (int phase = 0; phase < PHASES; phase++) begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_period(),
                          pick_limit(), pick_limit(), pick_limit(), pick_limit());
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 77;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 77;
                end
                default: begin
                    idle_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            // In one unthrottled phase the receiver holds off for a long stretch while
            // items keep coming, so the block fills and stalls its input.
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    pause_until_drained();
                end
                next_random_item(sp, ms);
                send_item(sp, ms);
            end
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** pid_controller_clamped_terms: PASSED **");
        end else begin
            $display("** pid_controller_clamped_terms: FAILED **");
        end
        $finish;
    end

endmodule
